// ===== rtl/tot_pkg.sv =====
// ----------------------------------------------------------------------------
// tot_pkg: shared definitions for the triangle overlap test
// Coordinate width default, result bus width, register indexes and actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tot_pkg;

  // Default coordinate width (legal range 8 to 30)
  localparam int COORD_WIDTH_DEF = 16;

  // Result bus width: one hit bit, padded to a byte
  localparam int OUT_DW = 8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_REF_AX = 3'd0,
    CFG_REF_AY = 3'd1,
    CFG_REF_BX = 3'd2,
    CFG_REF_BY = 3'd3,
    CFG_REF_CX = 3'd4,
    CFG_REF_CY = 3'd5
  } cfg_idx_e;

  // Query kinds carried in tuser
  typedef enum logic {
    ACT_POINT   = 1'b0,
    ACT_OVERLAP = 1'b1
  } action_e;

endpackage

`default_nettype wire

// ===== rtl/triangle_overlap_test.sv =====
// ----------------------------------------------------------------------------
// triangle_overlap_test: point-in-triangle and triangle overlap test
// Holds a reference triangle and answers point and overlap queries.
// ----------------------------------------------------------------------------
// The block takes one query transaction per clock while the result side is
// not stalled and returns one hit bit per query, in order. The rate, one item
// per cycle without stalls, is set by the 36 parallel multipliers of the
// cross-product stage, each (COORD_WIDTH+1) bits square, followed by one
// register. Pipeline: input register, coordinate differences and bounding-box
// compares, products, cross-product signs, result register. Each stage
// advances when its successor is empty or advancing, so bubbles collapse and
// new queries are taken while a result waits on the output. tuser = action:
// 0 tests the point (q_ax, q_ay) against the reference triangle, 1 tests the
// query triangle for overlap by vertex containment (edge-only crossings are
// not reported). Edge points count as inside for one winding only. The user
// must write the reference triangle registers through the cfg port only while
// no query is in flight (not enforced); writes to indexes 6 and 7 are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_overlap_test #(
  parameter int COORD_WIDTH = tot_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [2:0]                         cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]             cfg_data_i,
  // Query stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata, lowest bit up: q_ax, q_ay, q_bx, q_by, q_cx, q_cy, zero pad
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: action
  input  wire logic                               s_axis_tuser,
  // Result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata, lowest bit up: hit, zero pad
  output logic [tot_pkg::OUT_DW-1:0]              m_axis_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;     // coordinate difference
  localparam int PW = 2 * DW;     // product
  localparam int XW = PW + 1;     // cross product
  localparam int NT = 6;          // point tests
  localparam int NE = 3;          // edges per test

  typedef logic signed [CW-1:0] coord_t;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // --------------------------------------------------------------------------
  // Reference triangle registers
  // --------------------------------------------------------------------------
  coord_t ref_x_q [NE];
  coord_t ref_y_q [NE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NE; i++) begin
        ref_x_q[i] <= '0;
        ref_y_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (tot_pkg::cfg_idx_e'(cfg_idx_i))
        tot_pkg::CFG_REF_AX: ref_x_q[0] <= cfg_data_i;
        tot_pkg::CFG_REF_AY: ref_y_q[0] <= cfg_data_i;
        tot_pkg::CFG_REF_BX: ref_x_q[1] <= cfg_data_i;
        tot_pkg::CFG_REF_BY: ref_y_q[1] <= cfg_data_i;
        tot_pkg::CFG_REF_CX: ref_x_q[2] <= cfg_data_i;
        tot_pkg::CFG_REF_CY: ref_y_q[2] <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor advances
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en_out;

  assign en_out = !out_v_q || m_axis_tready;
  assign en4    = !v4_q || en_out;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= s_axis_tvalid;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en4)    v4_q    <= v3_q;
      if (en_out) out_v_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  coord_t qx1_q [NE];
  coord_t qy1_q [NE];
  logic   act1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      act1_q <= s_axis_tuser;
      for (int i = 0; i < NE; i++) begin
        qx1_q[i] <= s_axis_tdata[(2*i)*CW +: CW];
        qy1_q[i] <= s_axis_tdata[(2*i+1)*CW +: CW];
      end
    end
  end

  // Tests 0..2: query vertex i against the reference triangle.
  // Tests 3..5: reference vertex i against the query triangle.
  coord_t pt_x [NT];
  coord_t pt_y [NT];
  coord_t tr_x [NT][NE];
  coord_t tr_y [NT][NE];
  coord_t lo_x [2];
  coord_t hi_x [2];
  coord_t lo_y [2];
  coord_t hi_y [2];

  logic signed [DW-1:0] da_d [NT][NE];
  logic signed [DW-1:0] db_d [NT][NE];
  logic signed [DW-1:0] dc_d [NT][NE];
  logic signed [DW-1:0] dd_d [NT][NE];
  logic [NT-1:0]        inbox_d;
  logic                 ovl_d;

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      pt_x[i]      = qx1_q[i];
      pt_y[i]      = qy1_q[i];
      pt_x[i+NE]   = ref_x_q[i];
      pt_y[i+NE]   = ref_y_q[i];
      for (int k = 0; k < NE; k++) begin
        tr_x[i][k]    = ref_x_q[k];
        tr_y[i][k]    = ref_y_q[k];
        tr_x[i+NE][k] = qx1_q[k];
        tr_y[i+NE][k] = qy1_q[k];
      end
    end
  end

  // Bounding boxes: index 0 reference, index 1 query
  always_comb begin
    lo_x[0] = min3(ref_x_q[0], ref_x_q[1], ref_x_q[2]);
    hi_x[0] = max3(ref_x_q[0], ref_x_q[1], ref_x_q[2]);
    lo_y[0] = min3(ref_y_q[0], ref_y_q[1], ref_y_q[2]);
    hi_y[0] = max3(ref_y_q[0], ref_y_q[1], ref_y_q[2]);
    lo_x[1] = min3(qx1_q[0], qx1_q[1], qx1_q[2]);
    hi_x[1] = max3(qx1_q[0], qx1_q[1], qx1_q[2]);
    lo_y[1] = min3(qy1_q[0], qy1_q[1], qy1_q[2]);
    hi_y[1] = max3(qy1_q[0], qy1_q[1], qy1_q[2]);
    ovl_d   = (lo_x[0] <= hi_x[1]) && (hi_x[0] >= lo_x[1]) &&
              (lo_y[0] <= hi_y[1]) && (hi_y[0] >= lo_y[1]);
  end

  // Edge e runs from vertex e to vertex e+1 (wrapping); the cross product is
  // (P - V1) x (V0 - V1) = da*db - dc*dd.
  always_comb begin
    int b;
    int k1;
    for (int t = 0; t < NT; t++) begin
      b = (t < NE) ? 0 : 1;
      inbox_d[t] = (lo_x[b] <= pt_x[t]) && (pt_x[t] <= hi_x[b]) &&
                   (lo_y[b] <= pt_y[t]) && (pt_y[t] <= hi_y[b]);
      for (int e = 0; e < NE; e++) begin
        k1 = (e == NE - 1) ? 0 : e + 1;
        da_d[t][e] = DW'(pt_x[t])  - DW'(tr_x[t][k1]);
        db_d[t][e] = DW'(tr_y[t][e]) - DW'(tr_y[t][k1]);
        dc_d[t][e] = DW'(tr_x[t][e]) - DW'(tr_x[t][k1]);
        dd_d[t][e] = DW'(pt_y[t])  - DW'(tr_y[t][k1]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: differences and box flags
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] da2_q [NT][NE];
  logic signed [DW-1:0] db2_q [NT][NE];
  logic signed [DW-1:0] dc2_q [NT][NE];
  logic signed [DW-1:0] dd2_q [NT][NE];
  logic [NT-1:0]        inbox2_q;
  logic                 ovl2_q;
  logic                 act2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      da2_q    <= da_d;
      db2_q    <= db_d;
      dc2_q    <= dc_d;
      dd2_q    <= dd_d;
      inbox2_q <= inbox_d;
      ovl2_q   <= ovl_d;
      act2_q   <= act1_q;
    end
  end

  logic signed [PW-1:0] m0_d [NT][NE];
  logic signed [PW-1:0] m1_d [NT][NE];

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      for (int e = 0; e < NE; e++) begin
        m0_d[t][e] = PW'(da2_q[t][e]) * PW'(db2_q[t][e]);
        m1_d[t][e] = PW'(dc2_q[t][e]) * PW'(dd2_q[t][e]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] m0_3_q [NT][NE];
  logic signed [PW-1:0] m1_3_q [NT][NE];
  logic [NT-1:0]        inbox3_q;
  logic                 ovl3_q;
  logic                 act3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      m0_3_q   <= m0_d;
      m1_3_q   <= m1_d;
      inbox3_q <= inbox2_q;
      ovl3_q   <= ovl2_q;
      act3_q   <= act2_q;
    end
  end

  logic signed [XW-1:0] cross_d [NT][NE];
  logic [NE-1:0]        le_d    [NT];

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      for (int e = 0; e < NE; e++) begin
        cross_d[t][e] = XW'(m0_3_q[t][e]) - XW'(m1_3_q[t][e]);
        le_d[t][e]    = cross_d[t][e][XW-1] || (cross_d[t][e] == '0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: cross-product signs
  // --------------------------------------------------------------------------
  logic [NE-1:0] le4_q [NT];
  logic [NT-1:0] inbox4_q;
  logic          ovl4_q;
  logic          act4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      le4_q    <= le_d;
      inbox4_q <= inbox3_q;
      ovl4_q   <= ovl3_q;
      act4_q   <= act3_q;
    end
  end

  // A point is contained when it lies in the box and all three signs agree
  logic [NT-1:0] cont_d;
  logic          hit_d;

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      cont_d[t] = inbox4_q[t] && (le4_q[t] == '0 || le4_q[t] == '1);
    end
    if (tot_pkg::action_e'(act4_q) == tot_pkg::ACT_OVERLAP) begin
      hit_d = ovl4_q && (|cont_d);
    end else begin
      hit_d = cont_d[0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tdata = {{(tot_pkg::OUT_DW-1){1'b0}}, hit_q};

endmodule

`default_nettype wire

// ===== rtl/tot_checker.sv =====
// ----------------------------------------------------------------------------
// tot_checker: port-level checks for the triangle overlap test
// Watches the stream handshakes and the result bus over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tot_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [tot_pkg::OUT_DW-1:0]    m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

  // Only the hit bit may be set
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[tot_pkg::OUT_DW-1:1] == '0))
    else $error("result padding not zero");

  // An empty output register means every stage can advance
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An accepted query reaches the output while the result side stays ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready)
      |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind triangle_overlap_test tot_checker u_tot_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
